// ----- rtl/tod_sched_pkg.sv -----
`default_nettype none

package tod_sched_pkg;

   // Field widths of the request and response beats.
   localparam int unsigned FUNC_W   = 2;
   localparam int unsigned SETVAL_W = 8;
   localparam int unsigned HOUR_W   = 5;
   localparam int unsigned MINUTE_W = 6;
   localparam int unsigned SECOND_W = 6;

   // Configuration port shape.
   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W  = 5;

   // Clock limits.
   localparam int unsigned HOUR_LAST   = 23;
   localparam int unsigned MINUTE_LAST = 59;
   localparam int unsigned SECOND_LAST = 59;

   // Default prescaler modulus.
   localparam int unsigned TICKS_PER_SECOND_DEF = 1000;

   // Reset values of the configuration registers.
   localparam logic              SCHED_EN_RST     = 1'b1;
   localparam logic [HOUR_W-1:0] WINDOW_START_RST = 5'd0;
   localparam logic [HOUR_W-1:0] WINDOW_END_RST   = 5'd8;

   // Request function codes.
   typedef enum logic [FUNC_W-1:0] {
      FUNC_TICK       = 2'd0,
      FUNC_SET_HOUR   = 2'd1,
      FUNC_SET_MINUTE = 2'd2,
      FUNC_QUERY      = 2'd3
   } func_type;

   // Configuration register indexes.
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SCHED_EN     = 2'd0,
      CSR_WINDOW_START = 2'd1,
      CSR_WINDOW_END   = 2'd2
   } csr_index_type;

endpackage

`default_nettype wire

// ----- rtl/time_of_day_schedule_window_core.sv -----
`default_nettype none

// Channel   Direction  Handshake             Payload
// req       in         req_valid / req_stall req_func, req_set_value
// rsp       out        rsp_valid / rsp_stall rsp_hour_now, rsp_minute_now,
//                                            rsp_second_now, rsp_in_window
// csr       in         csr_write_enable      csr_index, csr_wdata
//
// Each accepted request beat produces exactly one response beat in the cycle after it.
// The clock counters update in the cycle a beat is accepted; the response
// register then holds the new time and window flag, so one beat per cycle
// is sustained while the response side keeps up.
// Reset puts the clock at midnight and loads the register defaults.
// req_stall rises only while a response waits and rsp_stall is high.

module time_of_day_schedule_window_core #(
   parameter int unsigned TICKS_PER_SECOND = tod_sched_pkg::TICKS_PER_SECOND_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,

   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic [tod_sched_pkg::FUNC_W-1:0]    req_func,
   input  wire logic [tod_sched_pkg::SETVAL_W-1:0]  req_set_value,

   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic [tod_sched_pkg::HOUR_W-1:0]         rsp_hour_now,
   output logic [tod_sched_pkg::MINUTE_W-1:0]       rsp_minute_now,
   output logic [tod_sched_pkg::SECOND_W-1:0]       rsp_second_now,
   output logic                                     rsp_in_window,

   input  wire logic                                csr_write_enable,
   input  wire logic [tod_sched_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [tod_sched_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   localparam int unsigned PS_W = (TICKS_PER_SECOND > 1) ? $clog2(TICKS_PER_SECOND) : 1;
   localparam logic [PS_W-1:0] PS_LAST = PS_W'(TICKS_PER_SECOND - 1);

   localparam int unsigned HOUR_W   = tod_sched_pkg::HOUR_W;
   localparam int unsigned MINUTE_W = tod_sched_pkg::MINUTE_W;
   localparam int unsigned SECOND_W = tod_sched_pkg::SECOND_W;

   localparam logic [HOUR_W-1:0]   HOUR_LAST   = HOUR_W'(tod_sched_pkg::HOUR_LAST);
   localparam logic [MINUTE_W-1:0] MINUTE_LAST = MINUTE_W'(tod_sched_pkg::MINUTE_LAST);
   localparam logic [SECOND_W-1:0] SECOND_LAST = SECOND_W'(tod_sched_pkg::SECOND_LAST);

   // Clock state.
   logic [PS_W-1:0]     prescale_ff, prescale_in;
   logic [SECOND_W-1:0] seconds_ff, seconds_in;
   logic [MINUTE_W-1:0] minutes_ff, minutes_in;
   logic [HOUR_W-1:0]   hours_ff, hours_in;

   // Configuration registers.
   logic              sched_en_ff;
   logic [HOUR_W-1:0] window_start_ff;
   logic [HOUR_W-1:0] window_end_ff;

   // Response register.
   logic                rsp_valid_ff, rsp_valid_in;
   logic [HOUR_W-1:0]   rsp_hour_ff;
   logic [MINUTE_W-1:0] rsp_minute_ff;
   logic [SECOND_W-1:0] rsp_second_ff;
   logic                rsp_window_ff, rsp_window_in;

   logic                    req_accept;
   tod_sched_pkg::func_type func_code;
   logic                    carry_second, carry_minute, carry_hour;

   // A beat is taken whenever the response register is empty or draining.
   assign req_stall  = rsp_valid_ff & rsp_stall;
   assign req_accept = req_valid & ~req_stall;
   assign func_code  = tod_sched_pkg::func_type'(req_func);

   // Cascaded carries of the tick counter.
   assign carry_second = (prescale_ff == PS_LAST);
   assign carry_minute = carry_second & (seconds_ff == SECOND_LAST);
   assign carry_hour   = carry_minute & (minutes_ff == MINUTE_LAST);

   // Next time of day for the incoming beat.
   always_comb begin
      prescale_in = prescale_ff;
      seconds_in  = seconds_ff;
      minutes_in  = minutes_ff;
      hours_in    = hours_ff;
      if (req_accept) begin
         unique case (func_code)
            tod_sched_pkg::FUNC_TICK: begin
               prescale_in = carry_second ? '0 : prescale_ff + 1'b1;
               if (carry_second) begin
                  seconds_in = (seconds_ff == SECOND_LAST) ? '0 : seconds_ff + 1'b1;
               end
               if (carry_minute) begin
                  minutes_in = (minutes_ff == MINUTE_LAST) ? '0 : minutes_ff + 1'b1;
               end
               if (carry_hour) begin
                  hours_in = (hours_ff == HOUR_LAST) ? '0 : hours_ff + 1'b1;
               end
            end
            tod_sched_pkg::FUNC_SET_HOUR: begin
               hours_in = (req_set_value > tod_sched_pkg::SETVAL_W'(HOUR_LAST))
                          ? HOUR_LAST : req_set_value[HOUR_W-1:0];
            end
            tod_sched_pkg::FUNC_SET_MINUTE: begin
               minutes_in = (req_set_value > tod_sched_pkg::SETVAL_W'(MINUTE_LAST))
                            ? MINUTE_LAST : req_set_value[MINUTE_W-1:0];
            end
            tod_sched_pkg::FUNC_QUERY: begin
            end
            default: begin
            end
         endcase
      end
   end

   // Window check on the updated hour; start >= end wraps past midnight.
   always_comb begin
      if (!sched_en_ff) begin
         rsp_window_in = 1'b1;
      end else if (window_start_ff < window_end_ff) begin
         rsp_window_in = (hours_in >= window_start_ff) && (hours_in < window_end_ff);
      end else begin
         rsp_window_in = (hours_in >= window_start_ff) || (hours_in < window_end_ff);
      end
   end

   // Response valid holds while stalled, loads on every accepted beat.
   always_comb begin
      if (req_accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   // Clock state and response valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         prescale_ff  <= '0;
         seconds_ff   <= '0;
         minutes_ff   <= '0;
         hours_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         prescale_ff  <= prescale_in;
         seconds_ff   <= seconds_in;
         minutes_ff   <= minutes_in;
         hours_ff     <= hours_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Response payload.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_hour_ff   <= hours_in;
         rsp_minute_ff <= minutes_in;
         rsp_second_ff <= seconds_in;
         rsp_window_ff <= rsp_window_in;
      end
   end

   // Configuration writes; indexes beyond the list are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         sched_en_ff     <= tod_sched_pkg::SCHED_EN_RST;
         window_start_ff <= tod_sched_pkg::WINDOW_START_RST;
         window_end_ff   <= tod_sched_pkg::WINDOW_END_RST;
      end else if (csr_write_enable) begin
         unique case (tod_sched_pkg::csr_index_type'(csr_index))
            tod_sched_pkg::CSR_SCHED_EN:     sched_en_ff     <= csr_wdata[0];
            tod_sched_pkg::CSR_WINDOW_START: window_start_ff <= csr_wdata[HOUR_W-1:0];
            tod_sched_pkg::CSR_WINDOW_END:   window_end_ff   <= csr_wdata[HOUR_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hour_now   = rsp_hour_ff;
   assign rsp_minute_now = rsp_minute_ff;
   assign rsp_second_now = rsp_second_ff;
   assign rsp_in_window  = rsp_window_ff;

   // The counters never leave their ranges.
   a_time_range: assert property (@(posedge clock) disable iff (reset)
      (hours_ff <= HOUR_LAST) && (minutes_ff <= MINUTE_LAST) &&
      (seconds_ff <= SECOND_LAST) && (prescale_ff <= PS_LAST))
      else $error("time of day counter out of range");

   // Every accepted beat shows up in the response register next cycle.
   a_accept_to_rsp: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_valid_ff)
      else $error("accepted beat produced no response");

   // A query leaves the time of day untouched.
   a_query_holds: assert property (@(posedge clock) disable iff (reset)
      (req_accept && (func_code == tod_sched_pkg::FUNC_QUERY)) |=>
      ($stable(hours_ff) && $stable(minutes_ff) && $stable(seconds_ff) &&
       $stable(prescale_ff)))
      else $error("query changed the clock state");

   // The response reports the state the beat left behind.
   a_rsp_matches_state: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> ((rsp_hour_ff == hours_ff) && (rsp_minute_ff == minutes_ff) &&
                      (rsp_second_ff == seconds_ff)))
      else $error("response does not match clock state");

endmodule

`default_nettype wire

// ----- bench/tb_top.sv -----
`default_nettype none

module tb_top;
   import tod_sched_pkg::*;

   localparam int unsigned TPS         = TICKS_PER_SECOND_DEF;
   localparam int unsigned ITEM_TARGET = 2000;
   localparam int unsigned CYCLE_LIMIT = 10_000_000;

   // One response beat as the clock should report it.
   typedef struct packed {
      logic [HOUR_W-1:0]   hour;
      logic [MINUTE_W-1:0] minute;
      logic [SECOND_W-1:0] second;
      logic                in_window;
   } tod_reading_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [FUNC_W-1:0]      req_func = '0;
   logic [SETVAL_W-1:0]    req_set_value = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [HOUR_W-1:0]      rsp_hour_now;
   logic [MINUTE_W-1:0]    rsp_minute_now;
   logic [SECOND_W-1:0]    rsp_second_now;
   logic                   rsp_in_window;
   logic                   csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   // Local copy of the time of day and the window registers.
   int unsigned         tick_phase = 0;
   logic [SECOND_W-1:0] tod_second = '0;
   logic [MINUTE_W-1:0] tod_minute = '0;
   logic [HOUR_W-1:0]   tod_hour = '0;
   logic                sched_en = SCHED_EN_RST;
   logic [HOUR_W-1:0]   win_start = WINDOW_START_RST;
   logic [HOUR_W-1:0]   win_end = WINDOW_END_RST;

   tod_reading_type expected_readings[$];
   int unsigned  mismatch_count = 0;
   int unsigned  beats_sent = 0;
   logic         idle_on = 1'b1;
   int unsigned  hold_cycles = 0;

   time_of_day_schedule_window_core #(
      .TICKS_PER_SECOND(TPS)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_func         (req_func),
      .req_set_value    (req_set_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_hour_now     (rsp_hour_now),
      .rsp_minute_now   (rsp_minute_now),
      .rsp_second_now   (rsp_second_now),
      .rsp_in_window    (rsp_in_window),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always #1 clock = ~clock;

   // The window wraps midnight whenever start is not below end.
   function automatic logic hour_in_window(input logic [HOUR_W-1:0] h);
      if (!sched_en) return 1'b1;
      if (win_start < win_end) return (h >= win_start) && (h < win_end);
      return (h >= win_start) || (h < win_end);
   endfunction

   // Apply one accepted beat to the local clock and queue the reading it yields.
   function automatic void advance_time_of_day(input func_type op,
                                               input logic [SETVAL_W-1:0] value);
      tod_reading_type r;
      case (op)
         FUNC_TICK: begin
            if (tick_phase == TPS - 1) begin
               tick_phase = 0;
               if (tod_second == SECOND_LAST) begin
                  tod_second = '0;
                  if (tod_minute == MINUTE_LAST) begin
                     tod_minute = '0;
                     tod_hour = (tod_hour == HOUR_LAST) ? '0 : tod_hour + 1'b1;
                  end else begin
                     tod_minute = tod_minute + 1'b1;
                  end
               end else begin
                  tod_second = tod_second + 1'b1;
               end
            end else begin
               tick_phase++;
            end
         end
         FUNC_SET_HOUR: begin
            tod_hour = (value > HOUR_LAST) ? HOUR_W'(HOUR_LAST) : HOUR_W'(value);
         end
         FUNC_SET_MINUTE: begin
            tod_minute = (value > MINUTE_LAST) ? MINUTE_W'(MINUTE_LAST) : MINUTE_W'(value);
         end
         default: begin
         end
      endcase
      r.hour      = tod_hour;
      r.minute    = tod_minute;
      r.second    = tod_second;
      r.in_window = hour_in_window(tod_hour);
      expected_readings.push_back(r);
   endfunction

   function automatic void note_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= 10) $display("tb_top: mismatch: %s", what);
   endfunction

   // Set values are biased toward the saturation limit and values above it.
   function automatic logic [SETVAL_W-1:0] pick_set_value(input int unsigned last);
      case ($urandom_range(0, 3))
         0: return SETVAL_W'(last);
         1: return SETVAL_W'($urandom_range(last + 1, 255));
         2: return SETVAL_W'($urandom_range(0, 255));
         default: return SETVAL_W'($urandom_range(0, last));
      endcase
   endfunction

   function automatic logic [HOUR_W-1:0] pick_window_hour();
      if ($urandom_range(0, 3) == 0) return HOUR_W'($urandom_range(24, 31));
      return HOUR_W'($urandom_range(0, 23));
   endfunction

   // Send one request beat, with an occasional idle burst ahead of it.
   // Valid is left high so the next beat can follow back to back.
   task automatic send_clock_beat(input func_type op, input logic [SETVAL_W-1:0] value);
      int unsigned gap;
      if (idle_on && $urandom_range(0, 7) == 0) begin
         gap = $urandom_range(1, 11);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_func      <= op;
      req_set_value <= value;
      do @(posedge clock); while (req_stall !== 1'b0);
      advance_time_of_day(op, value);
      beats_sent++;
   endtask

   // Drop valid and wait for every outstanding reading to come back.
   task automatic wait_clock_idle();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_readings.size() != 0);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [CSR_DATA_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_wdata        <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
      case (idx)
         CSR_SCHED_EN:     sched_en = data[0];
         CSR_WINDOW_START: win_start = data;
         CSR_WINDOW_END:   win_end = data;
         default: begin
         end
      endcase
   endtask

   task automatic load_window(input logic [CSR_DATA_W-1:0] en_word,
                              input logic [HOUR_W-1:0] start_hour,
                              input logic [HOUR_W-1:0] end_hour);
      wait_clock_idle();
      write_csr(CSR_SCHED_EN, en_word);
      write_csr(CSR_WINDOW_START, start_hour);
      write_csr(CSR_WINDOW_END, end_hour);
   endtask

   // Tick until the prescaler sits on the last tick of the current second.
   task automatic tick_to_second_edge();
      int unsigned n;
      n = TPS - 1 - tick_phase;
      repeat (n) send_clock_beat(FUNC_TICK, SETVAL_W'($urandom));
   endtask

   // Queries, ticks and sets at and beyond the saturation limits.
   task automatic test_set_and_query();
      send_clock_beat(FUNC_QUERY, 8'hFF);
      send_clock_beat(FUNC_TICK, 8'h00);
      send_clock_beat(FUNC_SET_HOUR, 8'd23);
      send_clock_beat(FUNC_SET_HOUR, 8'd24);
      send_clock_beat(FUNC_SET_HOUR, 8'hFF);
      send_clock_beat(FUNC_SET_HOUR, 8'd0);
      send_clock_beat(FUNC_SET_MINUTE, 8'd59);
      send_clock_beat(FUNC_SET_MINUTE, 8'd60);
      send_clock_beat(FUNC_SET_MINUTE, 8'hFF);
      send_clock_beat(FUNC_SET_MINUTE, 8'd0);
      send_clock_beat(FUNC_SET_HOUR, 8'd17);
      send_clock_beat(FUNC_QUERY, 8'h00);
   endtask

   // Probe the hours on both sides of each window boundary.
   task automatic check_window(input logic [CSR_DATA_W-1:0] en_word,
                               input logic [HOUR_W-1:0] start_hour,
                               input logic [HOUR_W-1:0] end_hour);
      load_window(en_word, start_hour, end_hour);
      send_clock_beat(FUNC_SET_HOUR, SETVAL_W'(start_hour) - 1'b1);
      send_clock_beat(FUNC_SET_HOUR, SETVAL_W'(start_hour));
      send_clock_beat(FUNC_SET_HOUR, SETVAL_W'(end_hour) - 1'b1);
      send_clock_beat(FUNC_SET_HOUR, SETVAL_W'(end_hour));
   endtask

   task automatic test_window_edges();
      // Disabled schedule, with the upper data bits set to make sure only bit 0 counts.
      check_window(5'b11110, 5'd9, 5'd17);
      check_window(5'd1, 5'd9, 5'd17);
      // Window that wraps midnight.
      check_window(5'd1, 5'd22, 5'd6);
      // Equal start and end covers the whole day.
      check_window(5'd1, 5'd5, 5'd5);
      // Registers beyond the last hour are compared as written.
      check_window(5'd1, 5'd31, 5'd24);
   endtask

   // Carry from the prescaler into seconds while hour and minute sit at their last values.
   task automatic test_time_carries();
      send_clock_beat(FUNC_SET_HOUR, 8'd23);
      send_clock_beat(FUNC_SET_MINUTE, 8'd59);
      tick_to_second_edge();
      send_clock_beat(FUNC_TICK, 8'h55);
      send_clock_beat(FUNC_TICK, 8'hAA);
      send_clock_beat(FUNC_QUERY, 8'h00);
   endtask

   // Mostly set-then-tick sequences under changing windows, with some stray beats.
   task automatic test_random_traffic();
      int unsigned phase;
      int unsigned burst;
      int unsigned target;
      int unsigned share;
      target = beats_sent;
      // The remaining beats of the run are spread over the eight phases, or 16 per phase once the target is met.
      share  = (beats_sent < ITEM_TARGET) ? (ITEM_TARGET - beats_sent) / 8 : 16;
      for (phase = 0; phase < 8; phase++) begin
         idle_on = (phase < 6) ? ($urandom_range(0, 3) != 0) : 1'b0;
         case (phase)
            0: load_window(5'd1, 5'd0, 5'd23);
            1: load_window(5'd0, 5'd23, 5'd0);
            2: load_window(5'd1, 5'd31, 5'd31);
            3: load_window(5'd1, 5'd0, 5'd0);
            default: load_window(CSR_DATA_W'($urandom), pick_window_hour(), pick_window_hour());
         endcase
         target += share;
         while (beats_sent < target) begin
            if ($urandom_range(0, 9) < 7) begin
               send_clock_beat(FUNC_SET_HOUR, pick_set_value(HOUR_LAST));
               if ($urandom_range(0, 1) == 1) begin
                  send_clock_beat(FUNC_SET_MINUTE, pick_set_value(MINUTE_LAST));
               end
               burst = $urandom_range(1, 24);
               repeat (burst) send_clock_beat(FUNC_TICK, SETVAL_W'($urandom));
               send_clock_beat(FUNC_QUERY, SETVAL_W'($urandom));
            end else begin
               send_clock_beat(func_type'($urandom_range(0, 3)), SETVAL_W'($urandom));
            end
         end
      end
   endtask

   // Response stall in random bursts while idling is enabled.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall   <= 1'b0;
         hold_cycles <= 0;
      end else if (hold_cycles > 1) begin
         hold_cycles <= hold_cycles - 1;
      end else if (idle_on && $urandom_range(0, 11) == 0) begin
         rsp_stall   <= 1'b1;
         hold_cycles <= $urandom_range(1, 11);
      end else begin
         rsp_stall   <= 1'b0;
         hold_cycles <= 0;
      end
   end

   // Compare each accepted response beat with the oldest queued reading.
   always @(posedge clock) begin : check_readings
      tod_reading_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
         if (expected_readings.size() == 0) begin
            note_mismatch($sformatf("unexpected beat %0d:%0d:%0d window %0b",
                                    rsp_hour_now, rsp_minute_now, rsp_second_now,
                                    rsp_in_window));
         end else begin
            want = expected_readings.pop_front();
            if (rsp_hour_now !== want.hour) begin
               note_mismatch($sformatf("hour expected %0d got %0d", want.hour, rsp_hour_now));
            end
            if (rsp_minute_now !== want.minute) begin
               note_mismatch($sformatf("minute expected %0d got %0d",
                                       want.minute, rsp_minute_now));
            end
            if (rsp_second_now !== want.second) begin
               note_mismatch($sformatf("second expected %0d got %0d",
                                       want.second, rsp_second_now));
            end
            if (rsp_in_window !== want.in_window) begin
               note_mismatch($sformatf("in_window expected %0b got %0b at hour %0d",
                                       want.in_window, rsp_in_window, want.hour));
            end
         end
      end
   end

   // Give up if the run hangs.
   initial begin : watchdog
      int unsigned cycles;
      for (cycles = 0; cycles < CYCLE_LIMIT; cycles++) @(posedge clock);
      $display("tb_top: FAIL");
      $finish;
   end

   initial begin : main_sequence
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_set_and_query();
      test_window_edges();
      test_time_carries();
      test_random_traffic();
      wait_clock_idle();
      repeat (4) @(posedge clock);
      if (mismatch_count == 0 && expected_readings.size() == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ----- time_of_day_schedule_window_core.f -----
rtl/tod_sched_pkg.sv
rtl/time_of_day_schedule_window_core.sv
bench/tb_top.sv
